FILE: rtl/core/payout_switch_hopper_controller_macros.svh
// Assertion helpers used by the checker file of this block.
`ifndef PAYOUT_SWITCH_HOPPER_CONTROLLER_MACROS_SVH
`define PAYOUT_SWITCH_HOPPER_CONTROLLER_MACROS_SVH

// Clocked assertion that is switched off while reset is applied.
`define PSHC_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Same-cycle implication built on the clocked form.
`define PSHC_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons, msg) \
  `PSHC_ASSERT(lbl, clk, rst_n, (ante) |-> (cons), msg)

`endif

FILE: rtl/core/pshc_pkg.sv
package pshc_pkg;

  typedef enum logic [2:0] {
    PhIdle      = 3'd0,
    PhConfirm   = 3'd1,
    PhScanSw    = 3'd2,
    PhScanPay   = 3'd3,
    PhWaitClose = 3'd4,
    PhWaitOpen  = 3'd5
  } phase_e;

  typedef enum logic [1:0] {
    CfgDebounce     = 2'd0,
    CfgHopperPoll   = 2'd1,
    CfgScanAttempts = 2'd2
  } cfg_idx_e;

  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 8;
  localparam int unsigned TickW    = 8;
  localparam int unsigned AttW     = 4;
  localparam int unsigned CreditW  = 3;
  localparam int unsigned DispW    = 4;

  localparam logic [TickW-1:0]   DebounceReset  = 8'd5;
  localparam logic [TickW-1:0]   HopperPollReset = 8'd10;
  localparam logic [AttW-1:0]    ScanAttReset   = 4'd5;
  localparam logic [DispW-1:0]   DisplayZero    = 4'hF;
  localparam logic [TickW-1:0]   TickMax        = 8'hFF;

  localparam logic [CreditW-1:0] CreditTwo   = 3'd2;
  localparam logic [CreditW-1:0] CreditThree = 3'd3;
  localparam logic [CreditW-1:0] CreditFour  = 3'd4;
  localparam logic [CreditW-1:0] CreditLine  = 3'd7;

  // Credit is at most 7 in a 3-bit register, so the clip is implicit;
  // the display lines are active low.
  function automatic logic [DispW-1:0] show_credit(input logic [CreditW-1:0] c);
    show_credit = ~{1'b0, c};
  endfunction

endpackage

FILE: rtl/core/payout_switch_hopper_controller.sv
// Payout switch and coin hopper controller.
// Input channel (in_valid_i / in_stall_o) carries one sampled tick per
// transaction: the common payout line, the value-two, three and four switches
// and the hopper coin switch. Every tick produces exactly one output
// transaction (out_valid_o / out_stall_i) with the motor drive, the active-low
// credit display, a coin-counted strobe and a ghost-trigger strobe.
// A transaction is registered at the input, and when the pipeline next advances
// the state machine and counters update and the result register loads; results
// are presented from that register. One tick is taken every cycle while the
// receiver does not stall; the state update is a single pass through a small
// state machine with an 8-bit tick counter and a 4-bit attempt counter.
// When the receiver stalls, the result register holds its transaction, the
// input register holds its tick, and in_stall_o rises once the input register
// is also occupied; nothing is dropped or repeated.
// Reset returns the machine to idle with the motor off, the display showing
// zero credit and the timing registers at 5, 10 and 5.
// The configuration port writes register cfg_index_i with cfg_data_i on any
// edge with cfg_we_i high; it is meant to be used only while the block is idle.
module payout_switch_hopper_controller (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic                           payout_line_i,
  input  logic                           pay_two_i,
  input  logic                           pay_three_i,
  input  logic                           pay_four_i,
  input  logic                           hopper_open_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic                           motor_on_o,
  output logic [pshc_pkg::DispW-1:0]     display_drive_o,
  output logic                           coin_counted_o,
  output logic                           ghost_trigger_o,
  input  logic                           cfg_we_i,
  input  logic [pshc_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [pshc_pkg::CfgDataW-1:0]  cfg_data_i
);
  import pshc_pkg::*;

  // Configuration registers.
  logic [TickW-1:0] debounce_q, hopper_poll_q;
  logic [AttW-1:0]  scan_att_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      debounce_q    <= DebounceReset;
      hopper_poll_q <= HopperPollReset;
      scan_att_q    <= ScanAttReset;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_index_i))
        CfgDebounce:     debounce_q    <= cfg_data_i;
        CfgHopperPoll:   hopper_poll_q <= cfg_data_i;
        CfgScanAttempts: scan_att_q    <= cfg_data_i[AttW-1:0];
        default: ;
      endcase
    end
  end

  // The pipeline advances whenever the result register is empty or drained.
  logic in_valid_q;
  logic advance;
  logic in_accept;
  logic step;

  assign advance    = !out_valid_o || !out_stall_i;
  assign in_stall_o = in_valid_q && !advance;
  assign in_accept  = in_valid_i && !in_stall_o;
  assign step       = in_valid_q && advance;

  // Input register.
  logic payout_q, two_q, three_q, four_q, hopper_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_accept) begin
      in_valid_q <= 1'b1;
    end else if (advance) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      payout_q <= payout_line_i;
      two_q    <= pay_two_i;
      three_q  <= pay_three_i;
      four_q   <= pay_four_i;
      hopper_q <= hopper_open_i;
    end
  end

  // Controller state.
  phase_e              phase_q, phase_d;
  logic [TickW-1:0]    tick_q, tick_d;
  logic [AttW-1:0]     att_q, att_d;
  logic [CreditW-1:0]  credits_q, credits_d;
  logic [DispW-1:0]    display_q, display_d;
  logic                motor_q, motor_d;
  logic                coin_d, ghost_d;

  logic [TickW-1:0]    tick_inc;
  logic                deb_done, poll_done;
  logic                scan_run;
  phase_e              scan_phase;
  logic                sw_exhausted;
  logic [AttW-1:0]     pay_att;
  logic                start_pay;
  logic [CreditW-1:0]  start_credit;
  logic [CreditW-1:0]  credits_dec;

  assign tick_inc  = (tick_q == TickMax) ? tick_q : tick_q + 1'b1;
  assign deb_done  = tick_inc >= debounce_q;
  assign poll_done = tick_inc >= hopper_poll_q;

  // A scan sample runs from the confirm phase (as a switch scan from attempt
  // zero) or from either scan phase once the spacing has elapsed.
  assign scan_phase   = (phase_q == PhConfirm) ? PhScanSw : phase_q;
  assign sw_exhausted = (scan_phase == PhScanSw) &&
                        (((phase_q == PhConfirm) ? '0 : att_q) >= scan_att_q);
  assign pay_att      = (sw_exhausted || phase_q == PhConfirm) ? '0 : att_q;
  assign credits_dec  = credits_q - 1'b1;

  always_comb begin
    scan_run = 1'b0;
    case (phase_q)
      PhConfirm:            scan_run = deb_done && payout_q;
      PhScanSw, PhScanPay:  scan_run = deb_done;
      default:              scan_run = 1'b0;
    endcase
  end

  // Next-state logic.
  always_comb begin
    phase_d      = phase_q;
    tick_d       = tick_q;
    att_d        = att_q;
    credits_d    = credits_q;
    display_d    = display_q;
    motor_d      = motor_q;
    coin_d       = 1'b0;
    ghost_d      = 1'b0;
    start_pay    = 1'b0;
    start_credit = CreditLine;

    case (phase_q)
      PhConfirm, PhScanSw, PhScanPay: begin
        if (!deb_done) begin
          tick_d = tick_inc;
        end else begin
          tick_d = '0;
          if (phase_q == PhConfirm && !payout_q) begin
            phase_d = PhIdle;
          end
        end
      end
      PhWaitClose: begin
        if (poll_done) begin
          tick_d = '0;
          if (!hopper_q) begin
            phase_d = PhWaitOpen;
          end
        end else begin
          tick_d = tick_inc;
        end
      end
      PhWaitOpen: begin
        if (poll_done) begin
          tick_d = '0;
          if (hopper_q) begin
            coin_d    = 1'b1;
            credits_d = credits_dec;
            display_d = show_credit(credits_dec);
            if (credits_dec == '0) begin
              motor_d = 1'b0;
              phase_d = PhIdle;
            end else begin
              phase_d = PhWaitClose;
            end
          end
        end else begin
          tick_d = tick_inc;
        end
      end
      default: begin
        // Idle, and any code that means nothing.
        phase_d = PhIdle;
        if (payout_q) begin
          phase_d = PhConfirm;
          tick_d  = '0;
        end
      end
    endcase

    if (scan_run) begin
      if (scan_phase == PhScanSw && !sw_exhausted) begin
        if (two_q) begin
          start_pay = 1'b1; start_credit = CreditTwo;
        end else if (three_q) begin
          start_pay = 1'b1; start_credit = CreditThree;
        end else if (four_q) begin
          start_pay = 1'b1; start_credit = CreditFour;
        end else begin
          phase_d = PhScanSw;
          att_d   = pay_att + 1'b1;
        end
      end else if (pay_att >= scan_att_q) begin
        phase_d = PhIdle;
        att_d   = '0;
        ghost_d = 1'b1;
      end else if (payout_q) begin
        start_pay    = 1'b1;
        start_credit = CreditLine;
      end else begin
        phase_d = PhScanPay;
        att_d   = pay_att + 1'b1;
      end

      // A starting payout sets the attempt counter to pay_att, which is zero from confirm.
      if (start_pay) begin
        att_d     = pay_att;
        credits_d = start_credit;
        display_d = show_credit(start_credit);
        motor_d   = 1'b1;
        phase_d   = PhWaitClose;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PhIdle;
      tick_q    <= '0;
      att_q     <= '0;
      credits_q <= '0;
      display_q <= DisplayZero;
      motor_q   <= 1'b0;
    end else if (step) begin
      phase_q   <= phase_d;
      tick_q    <= tick_d;
      att_q     <= att_d;
      credits_q <= credits_d;
      display_q <= display_d;
      motor_q   <= motor_d;
    end
  end

  // Result register.
  logic out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= in_valid_q;
    end
  end

  logic                motor_out_q, coin_out_q, ghost_out_q;
  logic [DispW-1:0]    display_out_q;

  always_ff @(posedge clk_i) begin
    if (step) begin
      motor_out_q   <= motor_d;
      display_out_q <= display_d;
      coin_out_q    <= coin_d;
      ghost_out_q   <= ghost_d;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign motor_on_o      = motor_out_q;
  assign display_drive_o = display_out_q;
  assign coin_counted_o  = coin_out_q;
  assign ghost_trigger_o = ghost_out_q;

endmodule

FILE: rtl/core/pshc_checker.sv
`include "payout_switch_hopper_controller_macros.svh"

module pshc_checker (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           out_valid_o,
  input  logic                           out_stall_i,
  input  logic                           motor_on_o,
  input  logic [pshc_pkg::DispW-1:0]     display_drive_o,
  input  logic                           coin_counted_o,
  input  logic                           ghost_trigger_o
);
  import pshc_pkg::*;

  // A tick cannot both finish a coin and end a scan.
  `PSHC_ASSERT_IMPLY(a_coin_ghost_excl, clk_i, rst_ni, out_valid_o, !(coin_counted_o && ghost_trigger_o), "coin and ghost in one transaction")

  // A scan that ends empty never has the motor running.
  `PSHC_ASSERT_IMPLY(a_ghost_motor_off, clk_i, rst_ni, out_valid_o && ghost_trigger_o, !motor_on_o, "motor on at ghost trigger")

  // The last coin stops the motor and shows zero credit.
  `PSHC_ASSERT_IMPLY(a_last_coin_display, clk_i, rst_ni, out_valid_o && coin_counted_o && !motor_on_o, display_drive_o == DisplayZero, "display not cleared after last coin")

  // A stalled result stays in place.
  `PSHC_ASSERT(a_out_hold, clk_i, rst_ni, out_valid_o && out_stall_i |=> out_valid_o && $stable(display_drive_o), "stalled result changed")

endmodule

bind payout_switch_hopper_controller pshc_checker u_pshc_checker (.*);

FILE: tb/payout_switch_hopper_controller_tb.sv
`timescale 1ns / 100ps

module payout_switch_hopper_controller_tb;
  import pshc_pkg::*;

  localparam int unsigned ClkHalf       = 5;
  localparam int unsigned ResetCycles   = 7;
  localparam int unsigned RandomTicks   = 700;
  localparam int unsigned SettingsRuns  = 10;
  localparam int unsigned WatchdogLimit = 2000;
  localparam int unsigned SettleCycles  = 20;
  localparam int unsigned MaxReports    = 10;

  // One sampled 1 ms tick of the payout and hopper switches.
  typedef struct packed {
    logic payout_line;
    logic pay_two;
    logic pay_three;
    logic pay_four;
    logic hopper_open;
  } tick_t;

  // What the block shows after each tick.
  typedef struct packed {
    logic             motor_on;
    logic [DispW-1:0] display_drive;
    logic             coin_counted;
    logic             ghost_trigger;
  } payout_status_t;

  typedef enum logic { RowTick, RowCfg } row_kind_e;

  typedef struct packed {
    row_kind_e             kind;
    cfg_idx_e              idx;
    logic [CfgDataW-1:0]   data;
    tick_t                 stim;
    logic                  fixed;
    payout_status_t        want;
  } row_t;

  localparam payout_status_t StatusIdle  = '{1'b0, DisplayZero, 1'b0, 1'b0};
  localparam payout_status_t StatusGhost = '{1'b0, DisplayZero, 1'b0, 1'b1};
  localparam payout_status_t StatusNone  = '0;

  // Directed part. Rows with the fixed flag carry a hand-written expectation;
  // all others are predicted. Stimulus bits are line, two, three, four, hopper.
  localparam row_t DirectedRows [26] = '{
    // Straight out of reset, and switches without the payout line are ignored.
    '{RowTick, CfgDebounce,     8'd0,   5'b00000, 1'b1, StatusIdle},
    '{RowTick, CfgDebounce,     8'd0,   5'b01111, 1'b1, StatusIdle},
    '{RowCfg,  CfgDebounce,     8'd1,   5'b00000, 1'b0, StatusNone},
    '{RowCfg,  CfgHopperPoll,   8'd1,   5'b00000, 1'b0, StatusNone},
    '{RowCfg,  CfgScanAttempts, 8'd1,   5'b00000, 1'b0, StatusNone},
    // Trigger with every switch closed: switch two wins, then two coins.
    '{RowTick, CfgDebounce,     8'd0,   5'b10000, 1'b0, StatusNone},
    '{RowTick, CfgDebounce,     8'd0,   5'b11111, 1'b0, StatusNone},
    '{RowTick, CfgDebounce,     8'd0,   5'b00000, 1'b0, StatusNone},
    '{RowTick, CfgDebounce,     8'd0,   5'b00001, 1'b0, StatusNone},
    '{RowTick, CfgDebounce,     8'd0,   5'b00000, 1'b0, StatusNone},
    '{RowTick, CfgDebounce,     8'd0,   5'b00001, 1'b0, StatusNone},
    // Confirmed trigger where nothing is found in either scan phase.
    '{RowTick, CfgDebounce,     8'd0,   5'b10000, 1'b0, StatusNone},
    '{RowTick, CfgDebounce,     8'd0,   5'b10000, 1'b0, StatusNone},
    '{RowTick, CfgDebounce,     8'd0,   5'b00000, 1'b0, StatusNone},
    '{RowTick, CfgDebounce,     8'd0,   5'b00000, 1'b1, StatusGhost},
    // With zero attempts the first scan sample is already a ghost.
    '{RowCfg,  CfgScanAttempts, 8'd0,   5'b00000, 1'b0, StatusNone},
    '{RowTick, CfgDebounce,     8'd0,   5'b10000, 1'b0, StatusNone},
    '{RowTick, CfgDebounce,     8'd0,   5'b10000, 1'b1, StatusGhost},
    // Zero debounce spacing, payout line found in the second scan phase.
    '{RowCfg,  CfgScanAttempts, 8'd1,   5'b00000, 1'b0, StatusNone},
    '{RowCfg,  CfgDebounce,     8'd0,   5'b00000, 1'b0, StatusNone},
    '{RowTick, CfgDebounce,     8'd0,   5'b10000, 1'b0, StatusNone},
    '{RowTick, CfgDebounce,     8'd0,   5'b10000, 1'b0, StatusNone},
    '{RowTick, CfgDebounce,     8'd0,   5'b10000, 1'b0, StatusNone},
    // Poll spacing changed to zero while the hopper is running.
    '{RowCfg,  CfgHopperPoll,   8'd0,   5'b00000, 1'b0, StatusNone},
    '{RowTick, CfgDebounce,     8'd0,   5'b00000, 1'b0, StatusNone},
    '{RowTick, CfgDebounce,     8'd0,   5'b00001, 1'b0, StatusNone}
  };

  logic                clk           = 1'b0;
  logic                rst_n         = 1'b0;
  logic                in_valid      = 1'b0;
  logic                in_stall;
  logic                payout_line   = 1'b0;
  logic                pay_two       = 1'b0;
  logic                pay_three     = 1'b0;
  logic                pay_four      = 1'b0;
  logic                hopper_open   = 1'b0;
  logic                out_valid;
  logic                out_stall     = 1'b0;
  logic                motor_on;
  logic [DispW-1:0]    display_drive;
  logic                coin_counted;
  logic                ghost_trigger;
  logic                cfg_we        = 1'b0;
  logic [CfgIdxW-1:0]  cfg_index     = '0;
  logic [CfgDataW-1:0] cfg_data      = '0;

  // Expectation of the tick currently offered, when it is written by hand.
  logic                row_fixed     = 1'b0;
  payout_status_t      row_want      = StatusNone;

  // Random idling is switched off for some settings to get back-to-back traffic.
  logic                source_calm   = 1'b0;
  logic                sink_calm     = 1'b0;

  payout_status_t      pending_status [$];
  int unsigned         mismatches      = 0;
  int unsigned         results_checked = 0;
  int unsigned         ticks_sent      = 0;
  int unsigned         coins_seen      = 0;
  int unsigned         ghosts_seen     = 0;
  int unsigned         quiet_cycles    = 0;

  // Predictor state and its copy of the timing registers.
  phase_e              ctl_phase;
  logic [TickW-1:0]    tick_cnt;
  logic [AttW-1:0]     scan_cnt;
  logic [CreditW-1:0]  credit_cnt;
  logic [DispW-1:0]    shown;
  logic                motor;
  logic [TickW-1:0]    debounce_cfg;
  logic [TickW-1:0]    poll_cfg;
  logic [AttW-1:0]     attempts_cfg;

  payout_switch_hopper_controller dut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .in_valid_i      (in_valid),
    .in_stall_o      (in_stall),
    .payout_line_i   (payout_line),
    .pay_two_i       (pay_two),
    .pay_three_i     (pay_three),
    .pay_four_i      (pay_four),
    .hopper_open_i   (hopper_open),
    .out_valid_o     (out_valid),
    .out_stall_i     (out_stall),
    .motor_on_o      (motor_on),
    .display_drive_o (display_drive),
    .coin_counted_o  (coin_counted),
    .ghost_trigger_o (ghost_trigger),
    .cfg_we_i        (cfg_we),
    .cfg_index_i     (cfg_index),
    .cfg_data_i      (cfg_data)
  );

  always #ClkHalf clk = ~clk;

  // Active-low display of a credit; a 3-bit credit never needs clipping.
  function automatic logic [DispW-1:0] credit_lines(input logic [CreditW-1:0] credit);
    return DisplayZero ^ {1'b0, credit};
  endfunction

  function automatic void begin_payout(input logic [CreditW-1:0] credit);
    credit_cnt = credit;
    shown      = credit_lines(credit);
    motor      = 1'b1;
    ctl_phase  = PhWaitClose;
    tick_cnt   = '0;
  endfunction

  // Counts one tick of a wait and tells whether the spacing has elapsed.
  // A spacing of zero is therefore met on the first tick, like a spacing of one.
  function automatic logic spacing_elapsed(input logic [TickW-1:0] limit);
    if (tick_cnt < TickMax) begin
      tick_cnt = tick_cnt + 1'b1;
    end
    return tick_cnt >= limit;
  endfunction

  // One scan sample; returns 1 when the scan gives up as a ghost trigger.
  // An exhausted switch search falls through to the payout line search at once.
  function automatic logic take_scan_sample(input tick_t s);
    tick_cnt = '0;
    if (ctl_phase == PhScanSw) begin
      if (scan_cnt >= attempts_cfg) begin
        ctl_phase = PhScanPay;
        scan_cnt  = '0;
      end else if (s.pay_two) begin
        begin_payout(CreditTwo);
        return 1'b0;
      end else if (s.pay_three) begin
        begin_payout(CreditThree);
        return 1'b0;
      end else if (s.pay_four) begin
        begin_payout(CreditFour);
        return 1'b0;
      end else begin
        scan_cnt = scan_cnt + 1'b1;
        return 1'b0;
      end
    end
    if (scan_cnt >= attempts_cfg) begin
      ctl_phase = PhIdle;
      scan_cnt  = '0;
      return 1'b1;
    end
    if (s.payout_line) begin
      begin_payout(CreditLine);
      return 1'b0;
    end
    scan_cnt = scan_cnt + 1'b1;
    return 1'b0;
  endfunction

  // Advances the predictor by one tick and returns the status it should show.
  function automatic payout_status_t predict_status(input tick_t s);
    payout_status_t st;
    st = StatusNone;
    case (ctl_phase)
      PhConfirm: begin
        if (spacing_elapsed(debounce_cfg)) begin
          tick_cnt = '0;
          if (s.payout_line) begin
            ctl_phase        = PhScanSw;
            scan_cnt         = '0;
            st.ghost_trigger = take_scan_sample(s);
          end else begin
            ctl_phase = PhIdle;
          end
        end
      end
      PhScanSw, PhScanPay: begin
        if (spacing_elapsed(debounce_cfg)) begin
          st.ghost_trigger = take_scan_sample(s);
        end
      end
      PhWaitClose: begin
        if (spacing_elapsed(poll_cfg)) begin
          tick_cnt = '0;
          if (!s.hopper_open) begin
            ctl_phase = PhWaitOpen;
          end
        end
      end
      PhWaitOpen: begin
        if (spacing_elapsed(poll_cfg)) begin
          tick_cnt = '0;
          if (s.hopper_open) begin
            st.coin_counted = 1'b1;
            credit_cnt      = credit_cnt - 1'b1;
            shown           = credit_lines(credit_cnt);
            if (credit_cnt == '0) begin
              motor     = 1'b0;
              ctl_phase = PhIdle;
            end else begin
              ctl_phase = PhWaitClose;
            end
          end
        end
      end
      default: begin
        ctl_phase = PhIdle;
        if (s.payout_line) begin
          ctl_phase = PhConfirm;
          tick_cnt  = '0;
        end
      end
    endcase
    st.motor_on      = motor;
    st.display_drive = shown;
    return st;
  endfunction

  // Random tick that mostly follows what the machine is waiting for, so that
  // scans succeed and coins get paid; one tick in ten is pure noise.
  function automatic tick_t shaped_tick();
    tick_t s;
    s = tick_t'($urandom_range(0, 31));
    if ($urandom_range(0, 9) == 0) begin
      return s;
    end
    case (ctl_phase)
      PhIdle: begin
        s.payout_line = 1'($urandom_range(0, 1));
      end
      PhConfirm, PhScanSw, PhScanPay: begin
        s.payout_line = ($urandom_range(0, 3) != 0);
        s.pay_two     = ($urandom_range(0, 4) == 0);
        s.pay_three   = ($urandom_range(0, 4) == 0);
        s.pay_four    = ($urandom_range(0, 4) == 0);
      end
      PhWaitClose: begin
        s.hopper_open = ($urandom_range(0, 3) == 0);
      end
      PhWaitOpen: begin
        s.hopper_open = ($urandom_range(0, 3) != 0);
      end
      default: begin
      end
    endcase
    return s;
  endfunction

  // Offers one tick transaction and returns at the edge where it is taken.
  // A random tick is drawn only after the previous one has updated the predictor.
  task automatic send_tick(input logic random, input tick_t s, input logic fixed,
                           input payout_status_t want);
    int unsigned gap;
    tick_t       stim;
    gap  = source_calm ? 0 : $urandom_range(0, 5);
    stim = s;
    @(negedge clk);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    if (random) begin
      stim = shaped_tick();
    end
    in_valid <= 1'b1;
    {payout_line, pay_two, pay_three, pay_four, hopper_open} <= stim;
    row_fixed = fixed;
    row_want  = want;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // Withdraws the input and waits until every predicted status has come back.
  task automatic drain_results();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_status.size() != 0) @(posedge clk);
  endtask

  task automatic program_reg(input cfg_idx_e idx, input logic [CfgDataW-1:0] value);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CfgDebounce:   debounce_cfg = value;
      CfgHopperPoll: poll_cfg     = value;
      default:       attempts_cfg = value[AttW-1:0];
    endcase
  endtask

  // Receiver: raises out_stall for a random stretch before each result, never while sink_calm is set.
  initial begin : result_sink
    int unsigned hold;
    forever begin
      @(negedge clk);
      hold = sink_calm ? 0 : $urandom_range(0, 5);
      if (hold != 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(negedge clk);
      end
      out_stall <= 1'b0;
      @(posedge clk);
      while (!(rst_n && out_valid)) @(posedge clk);
    end
  end

  // Both channels are watched at the same edge: a finished result is checked
  // against the oldest prediction, then an accepted tick is predicted.
  always @(posedge clk) begin : channel_monitor
    payout_status_t got;
    payout_status_t want;
    tick_t          seen;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        got = {motor_on, display_drive, coin_counted, ghost_trigger};
        results_checked++;
        if (pending_status.size() == 0) begin
          mismatches++;
          if (mismatches <= MaxReports) begin
            $display("Result %0d arrived with no prediction pending", results_checked);
          end
        end else begin
          want = pending_status.pop_front();
          coins_seen  += want.coin_counted;
          ghosts_seen += want.ghost_trigger;
          if (got.motor_on !== want.motor_on || got.display_drive !== want.display_drive ||
              got.coin_counted !== want.coin_counted ||
              got.ghost_trigger !== want.ghost_trigger) begin
            mismatches++;
            if (mismatches <= MaxReports) begin
              $display("Result %0d mismatch (expected/actual): motor %0b/%0b display %h/%h",
                       results_checked, want.motor_on, got.motor_on,
                       want.display_drive, got.display_drive);
              $display("  coin %0b/%0b ghost %0b/%0b", want.coin_counted, got.coin_counted,
                       want.ghost_trigger, got.ghost_trigger);
            end
          end
        end
      end
      if (in_valid && !in_stall) begin
        seen = {payout_line, pay_two, pay_three, pay_four, hopper_open};
        want = predict_status(seen);
        if (row_fixed) begin
          want = row_want;
        end
        pending_status.push_back(want);
        ticks_sent++;
      end
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (quiet_cycles >= WatchdogLimit) begin
        $display("No transaction on either channel for %0d cycles", quiet_cycles);
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

  initial begin : stimulus
    int unsigned         run;
    logic [CfgDataW-1:0] debounce_val;
    logic [CfgDataW-1:0] poll_val;
    logic [CfgDataW-1:0] attempts_val;

    ctl_phase    = PhIdle;
    tick_cnt     = '0;
    scan_cnt     = '0;
    credit_cnt   = '0;
    shown        = DisplayZero;
    motor        = 1'b0;
    debounce_cfg = DebounceReset;
    poll_cfg     = HopperPollReset;
    attempts_cfg = ScanAttReset;

    repeat (ResetCycles) @(negedge clk);
    rst_n <= 1'b1;

    foreach (DirectedRows[i]) begin
      if (DirectedRows[i].kind == RowCfg) begin
        drain_results();
        program_reg(DirectedRows[i].idx, DirectedRows[i].data);
      end else begin
        send_tick(1'b0, DirectedRows[i].stim, DirectedRows[i].fixed, DirectedRows[i].want);
      end
    end

    // Random part: each run reprograms all three registers, usually while the
    // machine is partway through a wait, then sends shaped random ticks.
    for (run = 0; run < SettingsRuns; run++) begin
      drain_results();
      case (run)
        0: begin
          debounce_val = 8'd1;
          poll_val     = 8'd1;
          attempts_val = 8'd15;
        end
        1: begin
          debounce_val = 8'd0;
          poll_val     = 8'd0;
          attempts_val = 8'd0;
        end
        2: begin
          debounce_val = 8'd255;
          poll_val     = 8'd255;
          attempts_val = 8'd15;
        end
        default: begin
          debounce_val = 8'($urandom_range(1, 3));
          poll_val     = 8'($urandom_range(1, 3));
          attempts_val = ($urandom_range(0, 4) == 0) ? 8'd15 : 8'($urandom_range(0, 5));
        end
      endcase
      program_reg(CfgDebounce, debounce_val);
      program_reg(CfgHopperPoll, poll_val);
      program_reg(CfgScanAttempts, attempts_val);
      source_calm = (run % 3 == 2);
      sink_calm   = (run % 3 == 2) || (run % 5 == 4);
      repeat (RandomTicks / SettingsRuns) begin
        send_tick(1'b1, '0, 1'b0, StatusNone);
      end
    end

    drain_results();
    repeat (SettleCycles) @(posedge clk);

    $display("Sent %0d ticks over %0d register settings and checked %0d results.",
             ticks_sent, SettingsRuns + 1, results_checked);
    $display("Coins counted: %0d, ghost triggers: %0d, mismatches: %0d.",
             coins_seen, ghosts_seen, mismatches);
    if (mismatches == 0 && pending_status.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

FILE: filelist.f
+incdir+rtl/core
rtl/core/pshc_pkg.sv
rtl/core/payout_switch_hopper_controller.sv
rtl/core/pshc_checker.sv
tb/payout_switch_hopper_controller_tb.sv
